// ===== hw/rtl/agu_pkg.sv =====
// Package for the Adagrad parameter update block: widths, fixed-point
// constants, register indexes and the types shared between the modules.
// No dependencies.
`default_nettype none
package agu_pkg;
	localparam int W     = 32;              // data width
	localparam int F     = 16;              // fraction bits
	localparam int RADW  = W + F;           // sqrt radicand width
	localparam int ROOTW = RADW / 2;        // root width
	localparam int REMW  = ROOTW + 2;       // sqrt remainder width
	localparam int ADJW  = W + F;           // decayed rate width
	localparam int NUMW  = ADJW + W;        // step dividend width
	localparam int QW    = W + 1;           // step quotient width
	localparam int CNTW  = $clog2(ADJW);
	localparam int FIFO_DEPTH = 4;
	localparam int FPW   = $clog2(FIFO_DEPTH);

	localparam logic [W-1:0]   MAXU  = {W{1'b1}};
	localparam logic [W-1:0]   SMIN  = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0]   SMAX  = {1'b0, {(W-1){1'b1}}};
	localparam logic [2*W:0]   ONE_Q = (2*W+1)'(1) << F;

	typedef enum logic [2:0] {
		REG_LEARNING_RATE = 3'd0,
		REG_STEP_COUNT    = 3'd1,
		REG_DECAY_RATE    = 3'd2,
		REG_EPSILON       = 3'd3,
		REG_L2_WEIGHT     = 3'd4
	} agu_reg_t;

	// one element between front and back
	typedef struct packed {
		logic [W-1:0] x;
		logic         neg;
		logic [W-1:0] gm;
		logic [W-1:0] hn;
		logic         flag;
	} agu_item_t;

	// decayed rate unit status
	typedef struct packed {
		logic [ADJW-1:0] adj;
		logic            dflag;
		logic            busy;
	} agu_rate_t;
endpackage
`default_nettype wire

// ===== hw/rtl/agu_rate.sv =====
// Decayed learning rate unit: learning_rate / (1 + step_count*decay_rate),
// one quotient bit a cycle. Depends on agu_pkg.
`default_nettype none
module agu_rate import agu_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] learning_rate,
	input  wire logic [W-1:0] step_count,
	input  wire logic [W-1:0] decay_rate,
	output agu_rate_t         rate
);
	typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_LOAD, ST_DIV, ST_DONE} state_t;

	state_t          state_q;
	logic [2*W-1:0]  td_q;
	logic [W-1:0]    d_q;
	logic            dsat_q;
	logic [W-1:0]    rem_q;
	logic [ADJW-1:0] nq_q;
	logic [CNTW-1:0] cnt_q;
	logic [ADJW-1:0] adj_q;
	logic            dflag_q;

	logic [2*W:0]    dsum;
	logic [W:0]      r;
	logic            ge;

	assign dsum = {1'b0, td_q} + ONE_Q;
	assign r    = {rem_q, nq_q[ADJW-1]};
	assign ge   = r >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			td_q    <= '0;
			d_q     <= '0;
			dsat_q  <= 1'b0;
			rem_q   <= '0;
			nq_q    <= '0;
			cnt_q   <= '0;
			adj_q   <= '0;
			dflag_q <= 1'b0;
		end else if (start) begin
			state_q <= ST_MUL;
		end else begin
			case (state_q)
				ST_MUL: begin
					td_q    <= step_count * decay_rate;
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					dsat_q  <= |dsum[2*W:W];
					d_q     <= (|dsum[2*W:W]) ? MAXU : dsum[W-1:0];
					rem_q   <= '0;
					nq_q    <= {learning_rate, {F{1'b0}}};
					cnt_q   <= CNTW'(ADJW - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= ge ? W'(r - {1'b0, d_q}) : r[W-1:0];
					nq_q  <= {nq_q[ADJW-2:0], ge};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					adj_q   <= nq_q;
					dflag_q <= dsat_q;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rate.adj   = adj_q;
	assign rate.dflag = dflag_q;
	assign rate.busy  = (state_q != ST_IDLE);
endmodule
`default_nettype wire

// ===== hw/rtl/agu_front.sv =====
// Front pipeline: regularized gradient, its square and the new accumulator,
// four stages, pushing into the queue. Depends on agu_pkg.
`default_nettype none
module agu_front import agu_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output      logic         in_ready,
	input  wire logic [W-1:0] param_value,
	input  wire logic [W-1:0] gradient,
	input  wire logic [W-1:0] accum_sq,
	input  wire logic [W-1:0] l2_weight,
	input  wire logic         busy,
	input  wire logic         q_full,
	output      logic         push,
	output      agu_item_t    push_item
);
	logic en;
	logic v_s1, v_s2, v_s3, v_s4;
	logic [2*W-1:0] p_s1, sqm_s3;
	logic           neg_s1;
	logic [W-1:0]   x_s1, g_s1, h_s1;
	logic [W-1:0]   x_s2, gm_s2, h_s2, x_s3, gm_s3, h_s3;
	logic           neg_s2, flag_s2, neg_s3, flag_s3;
	agu_item_t      item_s4;

	logic [W-1:0]   nc_mag, x_mag, lim, pm, pr, s, sfin, gm;
	logic [2*W-1:0] psh, sqsh;
	logic           psat, ovf, sqsat, hcarry;
	logic [W-1:0]   sqc;
	logic [W:0]     hsum;

	assign en       = !v_s4 || !q_full;
	assign in_ready = en && !busy;
	assign push     = v_s4 && !q_full;
	assign push_item = item_s4;

	assign nc_mag = l2_weight[W-1] ? (~l2_weight + 1'b1) : l2_weight;
	assign x_mag  = param_value[W-1] ? (~param_value + 1'b1) : param_value;

	assign psh  = p_s1 >> F;
	assign lim  = neg_s1 ? SMIN : SMAX;
	assign psat = psh > {{W{1'b0}}, lim};
	assign pm   = psat ? lim : psh[W-1:0];
	assign pr   = neg_s1 ? (~pm + 1'b1) : pm;
	assign s    = g_s1 + pr;
	assign ovf  = (g_s1[W-1] == pr[W-1]) && (s[W-1] != g_s1[W-1]);
	assign sfin = ovf ? (g_s1[W-1] ? SMIN : SMAX) : s;
	assign gm   = sfin[W-1] ? (~sfin + 1'b1) : sfin;

	assign sqsh   = sqm_s3 >> F;
	assign sqsat  = |sqsh[2*W-1:W];
	assign sqc    = sqsat ? MAXU : sqsh[W-1:0];
	assign hsum   = {1'b0, h_s3} + {1'b0, sqc};
	assign hcarry = hsum[W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid && in_ready;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1    <= nc_mag * x_mag;
			neg_s1  <= l2_weight[W-1] ^ param_value[W-1];
			x_s1    <= param_value;
			g_s1    <= gradient;
			h_s1    <= accum_sq;
			x_s2    <= x_s1;
			neg_s2  <= sfin[W-1];
			gm_s2   <= gm;
			h_s2    <= h_s1;
			flag_s2 <= psat || ovf;
			sqm_s3  <= gm_s2 * gm_s2;
			x_s3    <= x_s2;
			neg_s3  <= neg_s2;
			gm_s3   <= gm_s2;
			h_s3    <= h_s2;
			flag_s3 <= flag_s2;
			item_s4.x    <= x_s3;
			item_s4.neg  <= neg_s3;
			item_s4.gm   <= gm_s3;
			item_s4.hn   <= hcarry ? MAXU : hsum[W-1:0];
			item_s4.flag <= flag_s3 || sqsat || hcarry;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/agu_fifo.sv =====
// Short queue between front and back pipelines.
// Depends on agu_pkg.
`default_nettype none
module agu_fifo import agu_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire agu_item_t push_item,
	input  wire logic      pop,
	output      logic      full,
	output      logic      valid,
	output      agu_item_t pop_item
);
	agu_item_t      mem [FIFO_DEPTH];
	logic [FPW-1:0] wr_q, rd_q;
	logic [FPW:0]   cnt_q;

	assign full     = cnt_q == (FPW+1)'(FIFO_DEPTH);
	assign valid    = cnt_q != '0;
	assign pop_item = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= push_item;
	end
endmodule
`default_nettype wire

// ===== hw/rtl/agu_back.sv =====
// Back pipeline: square root, denominator, step division and parameter
// update, ending in the output register. Depends on agu_pkg.
`default_nettype none
module agu_back import agu_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	input  wire agu_item_t       q_item,
	output      logic            pop,
	input  wire logic [W-1:0]    epsilon,
	input  wire agu_rate_t       rate,
	output      logic            out_valid,
	input  wire logic            out_ready,
	output      logic [W-1:0]    new_param,
	output      logic [W-1:0]    new_accum,
	output      logic            saturated
);
	logic en;
	logic out_v_q;
	logic [W-1:0] res_q, hn_q;
	logic         flag_q;

	assign en  = !out_v_q || out_ready;
	assign pop = en && q_valid;

	// square root, one result bit a stage
	logic            sq_v    [ROOTW+1];
	agu_item_t       sq_item [ROOTW+1];
	logic [REMW-1:0] sq_rem  [ROOTW+1];
	logic [ROOTW-1:0] sq_root [ROOTW+1];
	logic [RADW-1:0] sq_rad  [ROOTW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sq_v[0] <= 1'b0;
		else if (en) sq_v[0] <= q_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sq_item[0] <= q_item;
			sq_rem[0]  <= '0;
			sq_root[0] <= '0;
			sq_rad[0]  <= {q_item.hn, {F{1'b0}}};
		end
	end

	for (genvar k = 0; k < ROOTW; k++) begin : g_sqrt
		logic [REMW+1:0] r2, trial;
		logic            ge;
		assign r2    = {sq_rem[k], sq_rad[k][RADW-1 -: 2]};
		assign trial = {{(REMW-ROOTW){1'b0}}, sq_root[k], 2'b01};
		assign ge    = r2 >= trial;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_v[k+1] <= 1'b0;
			else if (en) sq_v[k+1] <= sq_v[k];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sq_item[k+1] <= sq_item[k];
				sq_rem[k+1]  <= ge ? REMW'(r2 - trial) : r2[REMW-1:0];
				sq_root[k+1] <= {sq_root[k][ROOTW-2:0], ge};
				sq_rad[k+1]  <= {sq_rad[k][RADW-3:0], 2'b00};
			end
		end
	end

	// denominator and partial products of rate * |g_reg|
	logic [W:0]      dsum;
	logic            v_p1, v_p2;
	agu_item_t       it_d, it_p1, it_p2;
	logic [W-1:0]    den_p1, den_p2;
	logic [2*W-1:0]  plo_p1, plo_p2;
	logic [ADJW-1:0] phi_p2;
	logic [NUMW-1:0] num;
	logic            big;

	assign dsum = {1'b0, sq_root[ROOTW]} + {1'b0, epsilon};
	assign num  = {phi_p2, {W{1'b0}}} + {{(NUMW-2*W){1'b0}}, plo_p2};
	assign big  = (num != '0) && (num[NUMW-1:QW] >= {{(NUMW-QW-W){1'b0}}, den_p2});

	// raise the flag on a saturated or zero denominator, or a saturated rate
	always_comb begin
		it_d      = sq_item[ROOTW];
		it_d.flag = sq_item[ROOTW].flag || dsum[W] || (dsum == '0) || rate.dflag;
	end

	// step division, one quotient bit a stage
	logic         dv_v    [QW+1];
	agu_item_t    dv_item [QW+1];
	logic [W-1:0] dv_den  [QW+1];
	logic         dv_big  [QW+1];
	logic [W-1:0] dv_rem  [QW+1];
	logic [QW-1:0] dv_nq  [QW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1     <= 1'b0;
			v_p2     <= 1'b0;
			dv_v[0]  <= 1'b0;
		end else if (en) begin
			v_p1    <= sq_v[ROOTW];
			v_p2    <= v_p1;
			dv_v[0] <= v_p2;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			it_p1      <= it_d;
			den_p1     <= dsum[W] ? MAXU : dsum[W-1:0];
			plo_p1     <= rate.adj[W-1:0] * sq_item[ROOTW].gm;
			it_p2      <= it_p1;
			den_p2     <= den_p1;
			plo_p2     <= plo_p1;
			phi_p2     <= rate.adj[ADJW-1:W] * it_p1.gm;
			dv_item[0] <= it_p2;
			dv_den[0]  <= den_p2;
			dv_big[0]  <= big;
			dv_rem[0]  <= num[QW+W-1:QW];
			dv_nq[0]   <= num[QW-1:0];
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_div
		logic [W:0] r;
		logic       ge;
		assign r  = {dv_rem[j], dv_nq[j][QW-1]};
		assign ge = r >= {1'b0, dv_den[j]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v[j+1] <= 1'b0;
			else if (en) dv_v[j+1] <= dv_v[j];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dv_item[j+1] <= dv_item[j];
				dv_den[j+1]  <= dv_den[j];
				dv_big[j+1]  <= dv_big[j];
				dv_rem[j+1]  <= ge ? W'(r - {1'b0, dv_den[j]}) : r[W-1:0];
				dv_nq[j+1]   <= {dv_nq[j][QW-2:0], ge};
			end
		end
	end

	// parameter update with saturation
	agu_item_t    fi;
	logic [W-1:0] room, res;
	logic [QW-1:0] stp;
	logic         over;

	assign fi   = dv_item[QW];
	// a zero denominator with a zero dividend moves nothing
	assign stp  = (dv_den[QW] == '0) ? '0 : dv_nq[QW];
	assign room = fi.neg ? (MAXU - (fi.x ^ SMIN)) : (fi.x ^ SMIN);
	assign over = dv_big[QW] || (stp > {1'b0, room});
	always_comb begin
		if (fi.neg) begin
			res = over ? SMAX : (fi.x + stp[W-1:0]);
		end else begin
			res = over ? SMIN : (fi.x - stp[W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (en) out_v_q <= dv_v[QW];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			res_q  <= res;
			hn_q   <= fi.hn;
			flag_q <= fi.flag || over;
		end
	end

	assign out_valid = out_v_q;
	assign new_param = res_q;
	assign new_accum = hn_q;
	assign saturated = flag_q;
endmodule
`default_nettype wire

// ===== hw/rtl/adagrad_param_update.sv =====
// Top level of the Adagrad parameter update block: configuration registers,
// front pipeline, queue, back pipeline. Depends on agu_pkg and its submodules.
`default_nettype none
// One Adagrad step per tensor element in Q16.16 fixed point. Send
// {accum_sq, gradient, param_value} on s_tdata; {new_accum, new_param} comes
// out on m_tdata with the saturated flag on m_tuser, in order, one result per
// element. The block takes one element per clock cycle when the output side
// keeps up and the rate unit is idle; m_tvalid rises once an accepted element
// has passed three more front stages, the queue, a 25-stage square root
// including its input register, three multiply stages, a 33-stage step divider
// and the output register. The queue and the output register let either side
// stall. Any configuration write starts the decayed-rate divider, which
// produces one quotient bit a cycle; s_tready stays low after the write until
// the divider is idle. Write configuration only while no element is in flight.
module adagrad_param_update import agu_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output      logic         s_tready,
	input  wire logic [95:0]  s_tdata,   // param_value, gradient, accum_sq
	output      logic         m_tvalid,
	input  wire logic         m_tready,
	output      logic [63:0]  m_tdata,   // new_param, new_accum
	output      logic [0:0]   m_tuser,   // saturated
	input  wire logic         cfg_wen,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);
	logic [W-1:0] learning_rate_q, step_count_q, decay_rate_q, epsilon_q, l2_weight_q;
	agu_rate_t    rate;
	logic         q_full, q_valid, push, pop;
	agu_item_t    push_item, pop_item;
	logic [W-1:0] new_param, new_accum;
	logic         saturated;

	// hold configuration; writes to unused indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learning_rate_q <= '0;
			step_count_q    <= '0;
			decay_rate_q    <= '0;
			epsilon_q       <= '0;
			l2_weight_q     <= '0;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_LEARNING_RATE: learning_rate_q <= cfg_data;
				REG_STEP_COUNT:    step_count_q    <= cfg_data;
				REG_DECAY_RATE:    decay_rate_q    <= cfg_data;
				REG_EPSILON:       epsilon_q       <= cfg_data;
				REG_L2_WEIGHT:     l2_weight_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// recompute the decayed rate after any write
	agu_rate u_rate (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (cfg_wen),
		.learning_rate (learning_rate_q),
		.step_count    (step_count_q),
		.decay_rate    (decay_rate_q),
		.rate          (rate)
	);

	agu_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (s_tvalid),
		.in_ready         (s_tready),
		.param_value      (s_tdata[31:0]),
		.gradient         (s_tdata[63:32]),
		.accum_sq         (s_tdata[95:64]),
		.l2_weight        (l2_weight_q),
		.busy             (rate.busy),
		.q_full           (q_full),
		.push             (push),
		.push_item        (push_item)
	);

	agu_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (q_full),
		.valid     (q_valid),
		.pop_item  (pop_item)
	);

	agu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (pop_item),
		.pop       (pop),
		.epsilon   (epsilon_q),
		.rate      (rate),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.new_param (new_param),
		.new_accum (new_accum),
		.saturated (saturated)
	);

	assign m_tdata = {new_accum, new_param};
	assign m_tuser = saturated;
endmodule
`default_nettype wire

// ===== hw/rtl/agu_checker.sv =====
// Port-level checks for adagrad_param_update and the bind that attaches them.
// Uses no package; the bind depends on adagrad_param_update.
`default_nettype none
module agu_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [95:0] s_tdata,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [63:0] m_tdata,
	input wire logic [0:0]  m_tuser,
	input wire logic        cfg_wen,
	input wire logic [2:0]  cfg_index,
	input wire logic [31:0] cfg_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("result beat dropped");
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");
	a_cfg_block: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wen |=> !s_tready) else $error("input taken while rate recomputes");
	a_cfg_block2: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wen |=> ##1 !s_tready) else $error("rate unit finished too early");
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !m_tvalid) else $error("result after reset");
endmodule

bind adagrad_param_update agu_checker u_chk (.*);
`default_nettype wire
